/* design/point_segment_distance_normal_top_defines.svh */
// Assertion macros shared by the checker of the point to segment distance block.
`ifndef POINT_SEGMENT_DISTANCE_NORMAL_TOP_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_NORMAL_TOP_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define PSD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define PSD_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/psd_pkg.sv */
// Types, constants and step functions of the point to segment distance block.
`timescale 1ns / 1ps
package psd_pkg;

   localparam int COORD_W    = 32;
   localparam int OFF_W      = 33;
   localparam int PROD_W     = 66;
   localparam int SUM_W      = 67;
   localparam int RAD_W      = 96;
   localparam int ROOT_W     = 48;
   localparam int REM_W      = 50;
   localparam int NUM_W      = 82;
   localparam int QUO_W      = 35;
   localparam int DIST_W     = 33;
   localparam int NORM_W     = 16;
   localparam int SQRT_STEPS = RAD_W / 2;
   localparam int DIV_STEPS  = QUO_W;
   localparam int RAD_SHIFT  = 28;
   localparam int DIST_SHIFT = 14;
   localparam int NORM_SHIFT = 28;

   localparam logic [DIST_W-1:0] DIST_TOP = '1;
   localparam logic [QUO_W-1:0]  UNIT_Q   = QUO_W'(16384);

   // What travels beside the arithmetic: case flags, cross magnitude, normal direction.
   typedef struct packed {
      logic              on_seg;
      logic              found;
      logic              sx;
      logic              sy;
      logic [SUM_W-1:0]  cmag;
      logic [OFF_W-1:0]  mx;
      logic [OFF_W-1:0]  my;
   } psd_job_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [ROOT_W-1:0] root;
      logic [REM_W-1:0]  rem;
      psd_job_type       job;
   } psd_sq_type;

   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [QUO_W-1:0]  nlo;
      logic [QUO_W-1:0]  quo;
   } psd_lane_type;

   typedef struct packed {
      logic [ROOT_W-1:0] s;
      psd_lane_type      ld;
      psd_lane_type      lx;
      psd_lane_type      ly;
      psd_job_type       job;
   } psd_dv_type;

   // One digit of the square root: bring down two radicand bits, try the next root bit.
   function automatic psd_sq_type psd_sq_step(input psd_sq_type a);
      psd_sq_type       r;
      logic [REM_W+1:0] t;
      logic [REM_W+1:0] trial;
      r     = a;
      t     = {a.rem, a.rad[RAD_W-1 -: 2]};
      trial = {2'b00, a.root, 2'b01};
      r.rad = {a.rad[RAD_W-3:0], 2'b00};
      if (t >= trial) begin
         r.rem  = REM_W'(t - trial);
         r.root = {a.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = t[REM_W-1:0];
         r.root = {a.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // One restoring division step of a lane against divisor s.
   function automatic psd_lane_type psd_lane_step(input psd_lane_type a,
                                                  input logic [ROOT_W-1:0] s);
      psd_lane_type    r;
      logic [ROOT_W:0] t;
      r     = a;
      t     = {a.rem, a.nlo[QUO_W-1]};
      r.nlo = {a.nlo[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, s}) begin
         r.rem = ROOT_W'(t - {1'b0, s});
         r.quo = {a.quo[QUO_W-2:0], 1'b1};
      end else begin
         r.rem = t[ROOT_W-1:0];
         r.quo = {a.quo[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // Clamp a quotient to one unit and apply the component's sign; zero when szero is set.
   function automatic logic [NORM_W-1:0] psd_unit(input logic [QUO_W-1:0] q,
                                                 input logic neg,
                                                 input logic szero);
      logic [QUO_W-1:0] c;
      c = (q > UNIT_Q) ? UNIT_Q : q;
      if (szero) return '0;
      return neg ? NORM_W'(-c) : c[NORM_W-1:0];
   endfunction

endpackage

/* design/psd_front.sv */
// Front stages: offsets, products, sums and case selection.
`timescale 1ns / 1ps
module psd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [psd_pkg::COORD_W-1:0] x1,
   input  logic signed [psd_pkg::COORD_W-1:0] y1,
   input  logic signed [psd_pkg::COORD_W-1:0] x2,
   input  logic signed [psd_pkg::COORD_W-1:0] y2,
   input  logic signed [psd_pkg::COORD_W-1:0] px,
   input  logic signed [psd_pkg::COORD_W-1:0] py,
   output logic                               out_valid,
   input  logic                               out_ready,
   output psd_pkg::psd_sq_type                out_data
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   logic signed [psd_pkg::OFF_W-1:0] dx1_ff, dy1_ff, ax1_ff, ay1_ff, bx1_ff, by1_ff;
   logic                             dg1_ff;
   logic signed [psd_pkg::OFF_W-1:0] dx2_ff, dy2_ff, ax2_ff, ay2_ff, bx2_ff, by2_ff;
   logic                             dg2_ff;
   logic signed [psd_pkg::PROD_W-1:0] pdx_ff, pdy_ff, pt1_ff, pt2_ff;
   logic signed [psd_pkg::PROD_W-1:0] pa1_ff, pa2_ff, pb1_ff, pb2_ff, pc1_ff, pc2_ff;
   logic signed [psd_pkg::OFF_W-1:0] dx3_ff, dy3_ff, ax3_ff, ay3_ff, bx3_ff, by3_ff;
   logic                             dg3_ff;
   logic signed [psd_pkg::SUM_W-1:0] l2_ff, dot_ff, d1_ff, d2_ff, c_ff;
   psd_pkg::psd_sq_type              out_ff;

   logic                             on_seg, cpos, use_a;
   logic [psd_pkg::SUM_W-1:0]        sq;
   logic signed [psd_pkg::OFF_W:0]   ex, ey;
   psd_pkg::psd_sq_type              out_in;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: offsets.
   always_ff @(posedge clock) begin
      if (rdy1) begin
         dx1_ff <= {x2[31], x2} - {x1[31], x1};
         dy1_ff <= {y2[31], y2} - {y1[31], y1};
         ax1_ff <= {px[31], px} - {x1[31], x1};
         ay1_ff <= {py[31], py} - {y1[31], y1};
         bx1_ff <= {px[31], px} - {x2[31], x2};
         by1_ff <= {py[31], py} - {y2[31], y2};
         dg1_ff <= (x1 == x2) && (y1 == y2);
      end
   end

   // Stage 2: products.
   always_ff @(posedge clock) begin
      if (rdy2) begin
         pdx_ff <= dx1_ff * dx1_ff;
         pdy_ff <= dy1_ff * dy1_ff;
         pt1_ff <= ax1_ff * dx1_ff;
         pt2_ff <= ay1_ff * dy1_ff;
         pa1_ff <= ax1_ff * ax1_ff;
         pa2_ff <= ay1_ff * ay1_ff;
         pb1_ff <= bx1_ff * bx1_ff;
         pb2_ff <= by1_ff * by1_ff;
         pc1_ff <= bx1_ff * dy1_ff;
         pc2_ff <= by1_ff * dx1_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         ax2_ff <= ax1_ff;
         ay2_ff <= ay1_ff;
         bx2_ff <= bx1_ff;
         by2_ff <= by1_ff;
         dg2_ff <= dg1_ff;
      end
   end

   // Stage 3: squared lengths, projection and cross product.
   always_ff @(posedge clock) begin
      if (rdy3) begin
         l2_ff  <= {pdx_ff[65], pdx_ff} + {pdy_ff[65], pdy_ff};
         dot_ff <= {pt1_ff[65], pt1_ff} + {pt2_ff[65], pt2_ff};
         d1_ff  <= {pa1_ff[65], pa1_ff} + {pa2_ff[65], pa2_ff};
         d2_ff  <= {pb1_ff[65], pb1_ff} + {pb2_ff[65], pb2_ff};
         c_ff   <= {pc1_ff[65], pc1_ff} - {pc2_ff[65], pc2_ff};
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
         ax3_ff <= ax2_ff;
         ay3_ff <= ay2_ff;
         bx3_ff <= bx2_ff;
         by3_ff <= by2_ff;
         dg3_ff <= dg2_ff;
      end
   end

   // Stage 4: pick the case, the squared length to root and the normal direction.
   always_comb begin
      on_seg = !dg3_ff && !dot_ff[psd_pkg::SUM_W-1] && (dot_ff <= l2_ff);
      cpos   = !c_ff[psd_pkg::SUM_W-1] && (c_ff != '0);
      use_a  = d1_ff < d2_ff;
      if (dg3_ff) begin
         sq = d1_ff;
         ex = {ax3_ff[32], ax3_ff};
         ey = {ay3_ff[32], ay3_ff};
      end else if (on_seg) begin
         sq = l2_ff;
         ex = cpos ? {dy3_ff[32], dy3_ff} : -{dy3_ff[32], dy3_ff};
         ey = cpos ? -{dx3_ff[32], dx3_ff} : {dx3_ff[32], dx3_ff};
      end else if (use_a) begin
         sq = d1_ff;
         ex = {ax3_ff[32], ax3_ff};
         ey = {ay3_ff[32], ay3_ff};
      end else begin
         sq = d2_ff;
         ex = {bx3_ff[32], bx3_ff};
         ey = {by3_ff[32], by3_ff};
      end
      out_in            = '0;
      out_in.rad        = psd_pkg::RAD_W'({sq, psd_pkg::RAD_SHIFT'(0)});
      out_in.job.on_seg = on_seg;
      out_in.job.found  = dg3_ff ? (d1_ff != '0) : 1'b1;
      out_in.job.sx     = ex[psd_pkg::OFF_W];
      out_in.job.sy     = ey[psd_pkg::OFF_W];
      out_in.job.mx     = ex[psd_pkg::OFF_W] ? psd_pkg::OFF_W'(-ex) : ex[psd_pkg::OFF_W-1:0];
      out_in.job.my     = ey[psd_pkg::OFF_W] ? psd_pkg::OFF_W'(-ey) : ey[psd_pkg::OFF_W-1:0];
      out_in.job.cmag   = c_ff[psd_pkg::SUM_W-1] ? psd_pkg::SUM_W'(-c_ff) : c_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy4) out_ff <= out_in;
   end

   assign out_valid = v4_ff;
   assign out_data  = out_ff;

endmodule

/* design/psd_sqrt_cell.sv */
// One square root cell: a root digit per transaction, handed to the next cell.
`timescale 1ns / 1ps
module psd_sqrt_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  psd_pkg::psd_sq_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output psd_pkg::psd_sq_type out_data
);

   logic                valid_ff;
   psd_pkg::psd_sq_type data_ff;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready) data_ff <= psd_pkg::psd_sq_step(in_data);
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* design/psd_div_cell.sv */
// One divider cell: a quotient bit for each of the three lanes per transaction.
`timescale 1ns / 1ps
module psd_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  psd_pkg::psd_dv_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output psd_pkg::psd_dv_type out_data
);

   logic                valid_ff;
   psd_pkg::psd_dv_type data_ff;
   psd_pkg::psd_dv_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in    = in_data;
      data_in.ld = psd_pkg::psd_lane_step(in_data.ld, in_data.s);
      data_in.lx = psd_pkg::psd_lane_step(in_data.lx, in_data.s);
      data_in.ly = psd_pkg::psd_lane_step(in_data.ly, in_data.s);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* design/point_segment_distance_normal_top.sv */
// Top level of the point to segment distance and unit normal block.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | segment endpoints and query point, Q16.16
//   rsp_    | out       | rsp_valid/rsp_stall  | distance Q17.16, normal Q2.14, found
//
// One transaction enters per cycle while req_stall is low; each gives exactly one result, in order.
// The path runs through 4 front stages, 48 root cells, 35 divider cells and 1 output register.
// The root chain gives one digit a cell and the divider chain one quotient bit a cell.
// Reset is synchronous and clears only the valid bits of every stage.
// A stall holds the output register; stages behind it keep filling bubbles, so
// req_stall rises only once every stage holds a transaction.
`timescale 1ns / 1ps
module point_segment_distance_normal_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_seg_x1,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_seg_y1,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_seg_x2,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_seg_y2,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_point_x,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_point_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic        [psd_pkg::DIST_W-1:0]    rsp_distance,
   output logic signed [psd_pkg::NORM_W-1:0]    rsp_normal_x,
   output logic signed [psd_pkg::NORM_W-1:0]    rsp_normal_y,
   output logic                                 rsp_found
);

   localparam int NSQ = psd_pkg::SQRT_STEPS;
   localparam int NDV = psd_pkg::DIV_STEPS;

   logic                front_ready;

   // Root chain links: index 0 feeds the first cell, index NSQ leaves the last.
   logic                sq_valid [NSQ+1];
   logic                sq_ready [NSQ+1];
   psd_pkg::psd_sq_type sq_data  [NSQ+1];

   logic                dv_valid [NDV+1];
   logic                dv_ready [NDV+1];
   psd_pkg::psd_dv_type dv_data  [NDV+1];

   psd_pkg::psd_sq_type front_data;
   psd_pkg::psd_sq_type sq_last;
   psd_pkg::psd_dv_type dv_init;
   psd_pkg::psd_dv_type dv_last;

   logic [psd_pkg::NUM_W-1:0]  half, nd, nx, ny;
   logic [psd_pkg::ROOT_W:0]   round_len;
   logic [psd_pkg::QUO_W-1:0]  dist_pick;

   logic                          rsp_valid_ff;
   logic [psd_pkg::DIST_W-1:0]    distance_ff, distance_in;
   logic [psd_pkg::NORM_W-1:0]    normal_x_ff, normal_x_in;
   logic [psd_pkg::NORM_W-1:0]    normal_y_ff, normal_y_in;
   logic                          found_ff, found_in;
   logic                          out_ready;

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .x1        (req_seg_x1),
      .y1        (req_seg_y1),
      .x2        (req_seg_x2),
      .y2        (req_seg_y2),
      .px        (req_point_x),
      .py        (req_point_y),
      .out_valid (sq_valid[0]),
      .out_ready (sq_ready[0]),
      .out_data  (front_data)
   );

   assign req_stall = !front_ready;

   // Start the root with an empty remainder and root.
   always_comb begin
      sq_data[0]      = front_data;
      sq_data[0].root = '0;
      sq_data[0].rem  = '0;
   end

   for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
      psd_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[i]),
         .in_ready  (sq_ready[i]),
         .in_data   (sq_data[i]),
         .out_valid (sq_valid[i+1]),
         .out_ready (sq_ready[i+1]),
         .out_data  (sq_data[i+1])
      );
   end

   // Load the three dividends: the cross magnitude for the distance, the
   // normal direction for each component; all round by half the divisor.
   always_comb begin
      sq_last = sq_data[NSQ];
      half    = psd_pkg::NUM_W'(sq_last.root >> 1);
      nd      = (psd_pkg::NUM_W'(sq_last.job.cmag) << psd_pkg::DIST_SHIFT) + half;
      nx      = (psd_pkg::NUM_W'(sq_last.job.mx) << psd_pkg::NORM_SHIFT) + half;
      ny      = (psd_pkg::NUM_W'(sq_last.job.my) << psd_pkg::NORM_SHIFT) + half;
      dv_init        = '0;
      dv_init.s      = sq_last.root;
      dv_init.job    = sq_last.job;
      dv_init.ld.rem = psd_pkg::ROOT_W'(nd[psd_pkg::NUM_W-1:psd_pkg::QUO_W]);
      dv_init.ld.nlo = nd[psd_pkg::QUO_W-1:0];
      dv_init.lx.rem = psd_pkg::ROOT_W'(nx[psd_pkg::NUM_W-1:psd_pkg::QUO_W]);
      dv_init.lx.nlo = nx[psd_pkg::QUO_W-1:0];
      dv_init.ly.rem = psd_pkg::ROOT_W'(ny[psd_pkg::NUM_W-1:psd_pkg::QUO_W]);
      dv_init.ly.nlo = ny[psd_pkg::QUO_W-1:0];
   end

   assign dv_valid[0]   = sq_valid[NSQ];
   assign sq_ready[NSQ] = dv_ready[0];
   assign dv_data[0]    = dv_init;

   for (genvar j = 0; j < NDV; j++) begin : g_div
      psd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[j]),
         .in_ready  (dv_ready[j]),
         .in_data   (dv_data[j]),
         .out_valid (dv_valid[j+1]),
         .out_ready (dv_ready[j+1]),
         .out_data  (dv_data[j+1])
      );
   end

   // Finish: on the segment the distance is the rounded quotient, else the
   // rounded root; saturate, clamp the normal and apply its sign.
   always_comb begin
      dv_last     = dv_data[NDV];
      round_len   = {1'b0, dv_last.s} + (psd_pkg::ROOT_W+1)'(1 << (psd_pkg::DIST_SHIFT - 1));
      dist_pick   = dv_last.job.on_seg ? dv_last.ld.quo
                                       : psd_pkg::QUO_W'(round_len >> psd_pkg::DIST_SHIFT);
      distance_in = (dist_pick > psd_pkg::QUO_W'(psd_pkg::DIST_TOP))
                       ? psd_pkg::DIST_TOP
                       : dist_pick[psd_pkg::DIST_W-1:0];
      normal_x_in = psd_pkg::psd_unit(dv_last.lx.quo, dv_last.job.sx, dv_last.s == '0);
      normal_y_in = psd_pkg::psd_unit(dv_last.ly.quo, dv_last.job.sy, dv_last.s == '0);
      found_in    = dv_last.job.found;
   end

   assign out_ready      = !rsp_valid_ff || !rsp_stall;
   assign dv_ready[NDV]  = out_ready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (out_ready) rsp_valid_ff <= dv_valid[NDV];
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         distance_ff <= distance_in;
         normal_x_ff <= normal_x_in;
         normal_y_ff <= normal_y_in;
         found_ff    <= found_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = distance_ff;
   assign rsp_normal_x = normal_x_ff;
   assign rsp_normal_y = normal_y_ff;
   assign rsp_found    = found_ff;

endmodule

/* design/psd_checker.sv */
// Port checker of the point to segment distance block and its bind.
`timescale 1ns / 1ps
`include "point_segment_distance_normal_top_defines.svh"
module psd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic        [psd_pkg::DIST_W-1:0]  rsp_distance,
   input logic signed [psd_pkg::NORM_W-1:0]  rsp_normal_x,
   input logic signed [psd_pkg::NORM_W-1:0]  rsp_normal_y,
   input logic                               rsp_found
);

   logic unit_ok;
   logic empty_ok;

   assign unit_ok  = (rsp_normal_x <= 16384) && (rsp_normal_x >= -16384)
                  && (rsp_normal_y <= 16384) && (rsp_normal_y >= -16384);
   assign empty_ok = (rsp_distance == '0) && (rsp_normal_x == '0) && (rsp_normal_y == '0);

   `PSD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")
   `PSD_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable({rsp_distance, rsp_normal_x, rsp_normal_y, rsp_found}), "stalled result changed")
   `PSD_ASSERT(a_not_found, rsp_valid && !rsp_found |-> empty_ok, "missing point gives nonzero result")
   `PSD_ASSERT(a_unit, rsp_valid |-> unit_ok, "normal beyond one unit")
   `PSD_ASSERT_RST(a_reset, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind point_segment_distance_normal_top psd_checker u_psd_checker (.*);

/* sim/point_segment_distance_normal_top_tb.sv */
// Testbench for the point to segment distance and unit normal block.
`timescale 1ns / 1ps
module point_segment_distance_normal_top_tb;

   // One result as the block presents it.
   typedef struct {
      logic        [psd_pkg::DIST_W-1:0] distance;
      logic signed [psd_pkg::NORM_W-1:0] normal_x;
      logic signed [psd_pkg::NORM_W-1:0] normal_y;
      logic                              found;
   } psd_result_type;

   // Holds predicted results in order and checks each arriving one against the oldest.
   class psd_scoreboard;
      psd_result_type pending_q[$];
      int             errors;

      function new();
         errors = 0;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      // Floor of the square root of a radicand of up to 128 bits.
      function logic [63:0] root_of(logic [127:0] n);
         logic [63:0]  r;
         logic [63:0]  t;
         logic [127:0] tt;
         r = '0;
         for (int i = 63; i >= 0; i--) begin
            t  = r | (64'd1 << i);
            tt = 128'(t) * 128'(t);
            if (tt <= n) r = t;
         end
         return r;
      endfunction

      // Component over length, as Q2.14 with the component's sign.
      function logic [psd_pkg::NORM_W-1:0] unit_of(logic signed [127:0] c, logic [63:0] s);
         logic [127:0] m;
         logic [127:0] q;
         if (s == 0) return '0;
         m = c[127] ? -c : c;
         m = m & 128'h3_FFFF_FFFF;
         q = ((m << 28) + (s >> 1)) / s;
         if (q > 128'd16384) q = 128'd16384;
         return c[127] ? psd_pkg::NORM_W'(-q) : psd_pkg::NORM_W'(q);
      endfunction

      // Distance and normal along an offset from an endpoint.
      function psd_result_type toward(logic signed [127:0] ex, logic signed [127:0] ey);
         psd_result_type r;
         logic [127:0]   d2;
         logic [63:0]    s;
         logic [63:0]    d;
         d2 = ex * ex + ey * ey;
         s  = root_of(d2 << 28);
         d  = (s + 64'd8192) >> 14;
         r.distance = (d > 64'(psd_pkg::DIST_TOP)) ? psd_pkg::DIST_TOP
                                                   : d[psd_pkg::DIST_W-1:0];
         r.found    = (d2 != 0);
         r.normal_x = r.found ? unit_of(ex, s) : '0;
         r.normal_y = r.found ? unit_of(ey, s) : '0;
         return r;
      endfunction

      // Predict the result of one accepted transaction and queue it.
      function void note(logic signed [31:0] ax1, logic signed [31:0] ay1,
                         logic signed [31:0] ax2, logic signed [31:0] ay2,
                         logic signed [31:0] apx, logic signed [31:0] apy);
         logic signed [127:0] x1, y1, x2, y2, px, py, dx, dy, dot, c;
         logic [127:0]        l2, d1, d2, mag, q;
         logic [63:0]         s;
         psd_result_type      r;
         x1 = ax1; y1 = ay1; x2 = ax2; y2 = ay2; px = apx; py = apy;
         if (x1 == x2 && y1 == y2) begin
            r = toward(px - x1, py - y1);
         end else begin
            dx  = x2 - x1;
            dy  = y2 - y1;
            l2  = dx * dx + dy * dy;
            s   = root_of(l2 << 28);
            dot = (px - x1) * dx + (py - y1) * dy;
            if (!dot[127] && dot <= $signed(l2)) begin
               c   = (py - y2) * (x1 - x2) - (px - x2) * (y1 - y2);
               mag = c[127] ? -c : c;
               q   = ((mag << 14) + (s >> 1)) / s;
               r.distance = (q > 128'(psd_pkg::DIST_TOP)) ? psd_pkg::DIST_TOP
                                                          : q[psd_pkg::DIST_W-1:0];
               if (!c[127] && c != 0) begin
                  r.normal_x = unit_of(dy, s);
                  r.normal_y = unit_of(-dx, s);
               end else begin
                  r.normal_x = unit_of(-dy, s);
                  r.normal_y = unit_of(dx, s);
               end
               r.found = 1'b1;
            end else begin
               d1 = (px - x1) * (px - x1) + (py - y1) * (py - y1);
               d2 = (px - x2) * (px - x2) + (py - y2) * (py - y2);
               if (d1 < d2) r = toward(px - x1, py - y1);
               else r = toward(px - x2, py - y2);
               r.found = 1'b1;
            end
         end
         pending_q.push_back(r);
      endfunction

      // Compare one accepted result, field by field, with the oldest prediction.
      function void check(psd_result_type got);
         psd_result_type want;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result dist=%0d nx=%0d ny=%0d found=%0b", $time,
                     got.distance, got.normal_x, got.normal_y, got.found);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (got.distance !== want.distance) begin
            $display("%0t: distance expected %0d actual %0d", $time,
                     want.distance, got.distance);
            errors++;
         end
         if (got.normal_x !== want.normal_x) begin
            $display("%0t: normal_x expected %0d actual %0d", $time,
                     want.normal_x, got.normal_x);
            errors++;
         end
         if (got.normal_y !== want.normal_y) begin
            $display("%0t: normal_y expected %0d actual %0d", $time,
                     want.normal_y, got.normal_y);
            errors++;
         end
         if (got.found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
            errors++;
         end
      endfunction
   endclass

   localparam int QUERY_COUNT = 1250;
   localparam int DRAIN_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid   = 1'b0;
   logic                              req_stall;
   logic signed [psd_pkg::COORD_W-1:0] req_seg_x1 = '0;
   logic signed [psd_pkg::COORD_W-1:0] req_seg_y1 = '0;
   logic signed [psd_pkg::COORD_W-1:0] req_seg_x2 = '0;
   logic signed [psd_pkg::COORD_W-1:0] req_seg_y2 = '0;
   logic signed [psd_pkg::COORD_W-1:0] req_point_x = '0;
   logic signed [psd_pkg::COORD_W-1:0] req_point_y = '0;
   logic                              rsp_valid;
   logic                              rsp_stall   = 1'b0;
   logic        [psd_pkg::DIST_W-1:0] rsp_distance;
   logic signed [psd_pkg::NORM_W-1:0] rsp_normal_x;
   logic signed [psd_pkg::NORM_W-1:0] rsp_normal_y;
   logic                              rsp_found;

   psd_scoreboard sb = new();

   // Turn off receiver pressure while the sender runs without gaps.
   logic burst_mode = 1'b0;

   point_segment_distance_normal_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_seg_x1   (req_seg_x1),
      .req_seg_y1   (req_seg_y1),
      .req_seg_x2   (req_seg_x2),
      .req_seg_y2   (req_seg_y2),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_distance (rsp_distance),
      .rsp_normal_x (rsp_normal_x),
      .rsp_normal_y (rsp_normal_y),
      .rsp_found    (rsp_found)
   );

   always #10 clock = ~clock;

   // Sample both channels at the edge; values seen here are the pre-edge ones.
   always @(posedge clock) begin
      psd_result_type got;
      if (!reset && req_valid && !req_stall)
         sb.note(req_seg_x1, req_seg_y1, req_seg_x2, req_seg_y2, req_point_x, req_point_y);
      if (!reset && rsp_valid && !rsp_stall) begin
         got.distance = rsp_distance;
         got.normal_x = rsp_normal_x;
         got.normal_y = rsp_normal_y;
         got.found    = rsp_found;
         sb.check(got);
      end
   end

   // Random receiver stalls: mostly short, now and then a long hold.
   int stall_left = 0;
   always @(posedge clock) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (burst_mode || pick < 65) begin
         rsp_stall <= 1'b0;
      end else if (pick < 95) begin
         stall_left <= $urandom_range(0, 2);
         rsp_stall  <= 1'b1;
      end else begin
         stall_left <= $urandom_range(10, 40);
         rsp_stall  <= 1'b1;
      end
   end

   // Gap before the next transaction: mostly none or short, a few long.
   function int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (burst_mode || pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one transaction and hold it until accepted; keep valid high between back-to-back items.
   task automatic send_query(input logic signed [31:0] x1, input logic signed [31:0] y1,
                             input logic signed [31:0] x2, input logic signed [31:0] y2,
                             input logic signed [31:0] px, input logic signed [31:0] py);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_seg_x1  <= x1;
      req_seg_y1  <= y1;
      req_seg_x2  <= x2;
      req_seg_y2  <= y2;
      req_point_x <= px;
      req_point_y <= py;
      do @(posedge clock); while (req_stall);
   endtask

   // Coordinate from a mix of ranges: full width, small grid, whole units, near the extremes.
   function logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 2000)) - 1000;
         2: return ($signed($urandom_range(0, 200)) - 100) <<< 16;
         default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 15)
                                              : 32'sh8000_0000 + $urandom_range(0, 15);
      endcase
   endfunction

   task automatic random_query();
      logic signed [31:0] x1, y1, x2, y2, px, py;
      int mode, shape;
      logic [31:0] k;
      mode  = $urandom_range(0, 9);
      mode  = (mode < 3) ? 0 : (mode < 6) ? 2 : (mode < 9) ? 1 : 3;
      shape = $urandom_range(0, 9);
      x1 = rand_coord(mode); y1 = rand_coord(mode);
      x2 = rand_coord(mode); y2 = rand_coord(mode);
      px = rand_coord(mode); py = rand_coord(mode);
      case (shape)
         0: begin                          // degenerate segment
            x2 = x1; y2 = y1;
            if ($urandom_range(0, 3) == 0) begin px = x1; py = y1; end
         end
         1: begin                          // point on an endpoint
            if ($urandom_range(0, 1) == 1) begin px = x1; py = y1; end
            else begin px = x2; py = y2; end
         end
         2: begin                          // point on the segment, small grid
            x1 = rand_coord(1); y1 = rand_coord(1);
            k  = $urandom_range(0, 4);
            x2 = x1 + 4 * ($signed($urandom_range(0, 20)) - 10);
            y2 = y1 + 4 * ($signed($urandom_range(0, 20)) - 10);
            px = x1 + ((x2 - x1) / 4) * $signed(k);
            py = y1 + ((y2 - y1) / 4) * $signed(k);
         end
         3: begin                          // equidistant from both endpoints
            x1 = rand_coord(1); y1 = rand_coord(1);
            x2 = -x1; y2 = -y1;
            px = y1 * 3; py = -x1 * 3;
         end
         default: ;
      endcase
      send_query(x1, y1, x2, y2, px, py);
   endtask

   localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] CMIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE  = 32'sh0001_0000;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: degenerate segment, coincident and apart.
      send_query(ONE, ONE, ONE, ONE, ONE, ONE);
      send_query(0, 0, 0, 0, 0, 0);
      send_query(ONE, 0, ONE, 0, 4 * ONE, 4 * ONE);
      send_query(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX);
      // Foot on the segment: both sides of the line, on the line, on the exact bounds.
      send_query(0, 0, 4 * ONE, 0, 2 * ONE, 3 * ONE);
      send_query(0, 0, 4 * ONE, 0, 2 * ONE, -3 * ONE);
      send_query(0, 0, 4 * ONE, 0, ONE, 0);
      send_query(0, 0, 4 * ONE, 0, 0, 5 * ONE);
      send_query(0, 0, 4 * ONE, 0, 4 * ONE, -5 * ONE);
      send_query(0, 0, 0, 4 * ONE, 3, 2 * ONE);
      send_query(-ONE, -ONE, ONE, ONE, ONE, -ONE);
      // Foot outside: beyond each end; then a foot exactly on the first endpoint.
      send_query(0, 0, 4 * ONE, 0, -3 * ONE, ONE);
      send_query(0, 0, 4 * ONE, 0, 9 * ONE, -2 * ONE);
      send_query(0, 0, ONE, ONE, 2 * ONE, -2 * ONE);
      send_query(0, ONE, 0, ONE + 1, 0, ONE);
      // Field extremes.
      send_query(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN);
      send_query(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN);
      send_query(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX);
      send_query(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX);
      send_query(CMIN, 0, CMIN, 1, CMAX, 0);
      send_query(-1, -1, 1, 1, 32'sh5555_5555, 32'shAAAA_AAAA);

      // Hold the sender until the pipeline has drained completely.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);

      for (int i = 0; i < QUERY_COUNT; i++) begin
         // Run a stretch with no idling on either side now and then.
         if (i % 250 == 100) burst_mode <= 1'b1;
         if (i % 250 == 180) burst_mode <= 1'b0;
         random_query();
      end
      req_valid  <= 1'b0;
      burst_mode <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("point_segment_distance_normal_top verification clean");
      end else begin
         $display("point_segment_distance_normal_top verification failed");
      end
      $finish;
   end

   // Bound the run well beyond the slowest correct pass.
   initial begin
      #20_000_000;
      $display("point_segment_distance_normal_top verification failed");
      $finish;
   end

endmodule
